// ===== src/sha_pkg.sv =====
// ============================================================================
// SHA-256 package
// Constants, types and round functions shared by the hasher modules.
// ============================================================================
`default_nettype none
package sha_pkg;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_ABSORB,
        t_ST_COMPRESS,
        t_ST_PAD,
        t_ST_OUTPUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;   // write one byte into the block buffer
        logic [7:0] byte_val;
        logic       count_byte;  // advance the message length
        logic       start_comp;  // begin a 64-round compression
        logic       round_en;    // run one round
        logic       finish_comp; // add working variables into the hash
        logic       reinit;      // return hash and length to initial values
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0]  fill;        // byte position of the next block write
        logic [63:0] bit_len;     // byte count times eight
        logic        rounds_done; // all 64 rounds of the block have run
    } t_status;

    function automatic logic [31:0] f_init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6A09E667;
            3'd1:    v = 32'hBB67AE85;
            3'd2:    v = 32'h3C6EF372;
            3'd3:    v = 32'hA54FF53A;
            3'd4:    v = 32'h510E527F;
            3'd5:    v = 32'h9B05688C;
            3'd6:    v = 32'h1F83D9AB;
            default: v = 32'h5BE0CD19;
        endcase
        return v;
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic logic [31:0] f_ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== src/sha_datapath.sv =====
// ============================================================================
// SHA-256 datapath
// Message length, block words, message schedule and one round per cycle.
// ============================================================================
`default_nettype none
module sha_datapath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sha_pkg::t_cmd  i_cmd,
    output sha_pkg::t_status    o_status,
    output logic [255:0]        o_hash
);
    import sha_pkg::*;

    logic [63:0] r_count;
    logic [5:0]  r_wptr;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [6:0]  r_round;
    logic [31:0] w_cur, w_new, s0, s1, sig0, sig1, ch, maj, t1, t2;

    // The write pointer follows the byte count while absorbing and also
    // advances over padding, which does not add to the message length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_wptr <= '0;
        end else if (i_cmd.load_byte) begin
            r_wptr <= r_wptr + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_count <= '0;
        end else if (i_cmd.count_byte) begin
            r_count <= r_count + 64'd1;
        end
    end

    // Schedule word for this round: block words first, then the expansion.
    always_comb begin
        s0    = f_ror(r_w[1], 7) ^ f_ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = f_ror(r_w[14], 17) ^ f_ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = (r_round < 7'd16) ? r_w[0] : w_new;
        sig1  = f_ror(r_v[4], 6) ^ f_ror(r_v[4], 11) ^ f_ror(r_v[4], 25);
        ch    = r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6]));
        t1    = r_v[7] + sig1 + ch + ROUND_K[r_round[5:0]] + w_cur;
        sig0  = f_ror(r_v[0], 2) ^ f_ror(r_v[0], 13) ^ f_ror(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) | (r_v[2] & (r_v[0] | r_v[1]));
        t2    = sig0 + maj;
    end

    // Message bytes are assembled straight into the schedule window, big-endian
    // within each word. During the first sixteen rounds the window shifts the
    // block words out; afterwards it slides over the expanded schedule.
    always_ff @(posedge i_clk) begin
        if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_cur;
        end else if (i_cmd.load_byte) begin
            r_w[r_wptr[5:2]][{~r_wptr[1:0], 3'b000} +: 8] <= i_cmd.byte_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_comp) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
            r_round <= '0;
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_round <= r_round + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= f_init_hash(3'(i));
            end
        end else if (i_cmd.finish_comp) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    always_comb begin
        o_status.fill        = r_wptr;
        o_status.bit_len     = {r_count[60:0], 3'b000};
        o_status.rounds_done = r_round[6];
        for (int i = 0; i < 8; i++) begin
            o_hash[255-32*i -: 32] = r_h[i];
        end
    end

endmodule
`default_nettype wire

// ===== src/sha_control.sv =====
// ============================================================================
// SHA-256 controller
// Sequences byte absorption, padding, compression and digest output.
// ============================================================================
`default_nettype none
module sha_control (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [31:0]      i_data,
    input  wire logic [2:0]       i_nbytes,
    input  wire logic             i_last,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire sha_pkg::t_status i_status,
    output sha_pkg::t_cmd         o_cmd,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [2:0]            o_out_index
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_data;
    logic [2:0]  r_left;
    logic        r_last;
    logic        r_padding;  // padding byte already written
    logic        r_extra;    // length does not fit, another block follows
    logic        r_final;    // current compression is the last of the message
    logic [2:0]  r_idx;
    logic [7:0]  pad_byte;
    logic [2:0]  len_sel;
    logic        in_xfer, out_xfer, block_full;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = o_out_valid && i_out_ready;
    assign block_full = (i_status.fill == 6'd63);
    assign len_sel    = 3'(i_status.fill - LEN_OFFSET);
    assign pad_byte   = !r_padding ? PAD_BYTE :
                        (i_status.fill < LEN_OFFSET || r_extra) ? 8'h00 :
                        i_status.bit_len[63 - 8*len_sel -: 8];

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_ST_IDLE: begin
                if (in_xfer) begin
                    n_state = t_ST_ABSORB;
                end
            end
            t_ST_ABSORB: begin
                if (r_left != 3'd0) begin
                    if (block_full) begin
                        n_state = t_ST_COMPRESS;
                    end
                end else if (r_last) begin
                    n_state = t_ST_PAD;
                end else begin
                    n_state = t_ST_IDLE;
                end
            end
            t_ST_PAD: begin
                if (block_full) begin
                    n_state = t_ST_COMPRESS;
                end
            end
            t_ST_COMPRESS: begin
                if (i_status.rounds_done) begin
                    if (r_final) begin
                        n_state = t_ST_OUTPUT;
                    end else if (r_padding) begin
                        n_state = t_ST_PAD;
                    end else begin
                        n_state = t_ST_ABSORB;
                    end
                end
            end
            t_ST_OUTPUT: begin
                if (out_xfer && r_idx == 3'd7) begin
                    n_state = t_ST_IDLE;
                end
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = (r_state == t_ST_IDLE);
        o_out_valid = (r_state == t_ST_OUTPUT);
        o_out_index = r_idx;
        case (r_state)
            t_ST_ABSORB: begin
                if (r_left != 3'd0) begin
                    o_cmd.load_byte  = 1'b1;
                    o_cmd.count_byte = 1'b1;
                    o_cmd.byte_val   = r_data[31:24];
                    o_cmd.start_comp = block_full;
                end
            end
            t_ST_PAD: begin
                o_cmd.load_byte  = 1'b1;
                o_cmd.byte_val   = pad_byte;
                o_cmd.start_comp = block_full;
            end
            t_ST_COMPRESS: begin
                // After the last round the result is folded into the hash.
                o_cmd.round_en    = !i_status.rounds_done;
                o_cmd.finish_comp = i_status.rounds_done;
            end
            t_ST_OUTPUT: begin
                o_cmd.reinit = out_xfer && (r_idx == 3'd7);
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= t_ST_IDLE;
            r_idx     <= '0;
            r_padding <= 1'b0;
            r_extra   <= 1'b0;
            r_final   <= 1'b0;
            r_left    <= '0;
            r_last    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_data <= i_data;
                r_left <= (i_nbytes > 3'd4) ? 3'd4 : i_nbytes;
                r_last <= i_last;
            end
            if (r_state == t_ST_ABSORB && r_left != 3'd0) begin
                r_data <= {r_data[23:0], 8'h00};
                r_left <= r_left - 3'd1;
            end
            if (r_state == t_ST_PAD) begin
                r_padding <= 1'b1;
                if (block_full) begin
                    r_final <= r_padding && !r_extra;
                    r_extra <= 1'b0;
                end else if (!r_padding) begin
                    r_extra <= (i_status.fill >= LEN_OFFSET);
                end
            end
            if (r_state == t_ST_OUTPUT && out_xfer) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_padding <= 1'b0;
                    r_final   <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_in_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_state == t_ST_IDLE) else $error("input taken while busy");
    a_no_out_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_cmd.round_en) else $error("output during compression");
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_idx == 3'd7) |=> r_state == t_ST_IDLE && r_idx == 3'd0)
        else $error("digest sequence did not end");
`endif

endmodule
`default_nettype wire

// ===== src/sha256_message_hasher_unit.sv =====
// ============================================================================
// SHA-256 message hasher
// Streams message bytes in, emits the eight digest words per message.
// ============================================================================
// Each input transfer carries up to four bytes, MSB first, in tdata[31:0];
// tdata[34:32] is the byte count (5 to 7 count as 4) and tlast ends the
// message. Bytes are absorbed one per cycle except while a full block is
// compressed, and tready stays low until every byte of a transfer has been
// absorbed. Each full 64-byte block is compressed in the single shared round
// unit, which runs its rounds and then folds the result into the hash. On
// tlast, padding writes one byte per cycle up to the end of the block (two
// blocks when the length does not fit), each followed by its compression. The
// digest then comes out as eight transfers, word 0 first, with tuser = index
// and tlast on word 7.
`default_nettype none
module sha256_message_hasher_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // data_word[31:0], valid_bytes[34:32]
    input  wire logic        s_axis_tlast,  // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // digest_word
    output logic [2:0]       m_axis_tuser,  // word_index
    output logic             m_axis_tlast   // last_word
);
    import sha_pkg::*;

    t_cmd         cmd;
    t_status      status;
    logic [255:0] hash;
    logic [2:0]   idx;

    sha_control u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (s_axis_tdata[31:0]),
        .i_nbytes    (s_axis_tdata[34:32]),
        .i_last      (s_axis_tlast),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_index (idx)
    );

    sha_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .o_hash   (hash)
    );

    assign m_axis_tdata = hash[255 - 32*idx -: 32];
    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == 3'd7);

endmodule
`default_nettype wire

// ===== dv/sha256_message_hasher_unit_tb.sv =====
// ============================================================================
// SHA-256 message hasher testbench
// Streams directed and random messages into the hasher, predicts each digest
// with a behavioral SHA-256 and checks every output transfer in order.
// ============================================================================
`default_nettype none
module sha256_message_hasher_unit_tb;

    import sha_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;  // data_word[31:0], valid_bytes[34:32]
    logic        s_axis_tlast;  // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // digest_word
    logic [2:0]  m_axis_tuser;  // word_index
    logic        m_axis_tlast;  // last_word

    sha256_message_hasher_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    localparam int RANDOM_WORDS = 164;
    localparam int MAX_GAP      = 12;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_out;

    typedef struct packed {
        logic [31:0]  data;
        logic [2:0]   nbytes;
        logic         eom;
        logic         typed;
        logic [255:0] digest;
    } t_row;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    // Directed messages: empty, "abc" with junk in the unused byte, saturated
    // and zero byte counts, all-ones and all-zeros words, empty final words.
    localparam int N_ROWS = 16;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{32'h00000000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{32'h616263FF, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
        '{32'hFFFFFFFF, 3'd4, 1'b0, 1'b0, '0},
        '{32'h00000000, 3'd4, 1'b0, 1'b0, '0},
        '{32'h12345678, 3'd7, 1'b0, 1'b0, '0},
        '{32'h9ABCDEF0, 3'd5, 1'b0, 1'b0, '0},
        '{32'hFFFFFFFF, 3'd6, 1'b1, 1'b0, '0},
        '{32'hAABBCCDD, 3'd1, 1'b0, 1'b0, '0},
        '{32'h11223344, 3'd2, 1'b0, 1'b0, '0},
        '{32'hDEADBEEF, 3'd0, 1'b0, 1'b0, '0},
        '{32'h00000000, 3'd0, 1'b1, 1'b0, '0},
        '{32'hFFFFFFFF, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{32'h80000000, 3'd1, 1'b1, 1'b0, '0},
        '{32'hFFFFFFFF, 3'd4, 1'b0, 1'b0, '0},
        '{32'h5A5AA5A5, 3'd3, 1'b0, 1'b0, '0},
        '{32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, '0}
    };

    // Behavioral hash state.
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    logic [63:0] byte_count;

    t_digest_out digest_q [$];
    int          n_fail;
    int          n_words_in;
    int          n_messages;
    int          n_digest_words;
    bit          sender_done;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void init_hash_state();
        hash_state = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                       32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
        byte_count = '0;
    endfunction

    function automatic void compress_block_bytes();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        v = hash_state;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        block_bytes[byte_count[5:0]] = b;
        byte_count++;
        if (byte_count[5:0] == 6'd0)
            compress_block_bytes();
    endfunction

    function automatic void pad_and_finish();
        logic [63:0] bits;
        int          pos;
        bits = byte_count << 3;
        pos  = byte_count[5:0];
        block_bytes[pos++] = 8'h80;
        if (pos > 56) begin
            while (pos < 64) block_bytes[pos++] = 8'h00;
            compress_block_bytes();
            pos = 0;
        end
        while (pos < 56) block_bytes[pos++] = 8'h00;
        for (int i = 0; i < 8; i++)
            block_bytes[56+i] = bits[63-8*i -: 8];
        compress_block_bytes();
    endfunction

    // Runs one accepted word through the hash and queues the digest it ends.
    function automatic void hash_word(input t_row r);
        int          n;
        t_digest_out d;
        n = (r.nbytes > 3'd4) ? 4 : int'(r.nbytes);
        for (int i = 0; i < n; i++)
            absorb_byte(r.data[31-8*i -: 8]);
        n_words_in++;
        if (r.eom) begin
            pad_and_finish();
            for (int i = 0; i < 8; i++) begin
                d.word = r.typed ? r.digest[255-32*i -: 32] : hash_state[i];
                d.idx  = 3'(i);
                d.last = (i == 7);
                digest_q.push_back(d);
            end
            n_messages++;
            init_hash_state();
        end
    endfunction

    // Sends one word; valid stays high across back-to-back transfers.
    task automatic send_word(input t_row r, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, r.nbytes, r.data};
        s_axis_tlast  <= r.eom;
        do @(posedge i_clk); while (!s_axis_tready);
        hash_word(r);
    endtask

    function automatic int draw_gap(input bit busy);
        return busy ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Sender.
    initial begin
        t_row r;
        bit   busy;
        int   msg_len;
        int   sent;
        n_fail = 0; n_words_in = 0; n_messages = 0; n_digest_words = 0;
        sender_done = 1'b0;
        init_hash_state();
        foreach (block_bytes[i]) block_bytes[i] = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_ROWS; k++)
            send_word(DIRECTED[k], draw_gap(k % 5 == 0));
        s_axis_tvalid <= 1'b0;
        // Let the block drain completely before the random traffic.
        while (digest_q.size() != 0) @(posedge i_clk);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            busy = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       msg_len = $urandom_range(1, 3);
                1:       msg_len = $urandom_range(13, 16);
                2:       msg_len = $urandom_range(17, 40);
                default: msg_len = $urandom_range(1, 12);
            endcase
            if (msg_len > RANDOM_WORDS - sent)
                msg_len = RANDOM_WORDS - sent;
            for (int i = 0; i < msg_len; i++) begin
                r.data   = $urandom();
                r.nbytes = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                r.eom    = (i == msg_len - 1);
                r.typed  = 1'b0;
                r.digest = '0;
                send_word(r, draw_gap(busy));
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        sender_done = 1'b1;
    end

    // Receiver and checker.
    initial begin
        t_digest_out exp_d;
        int          gap;
        bit          busy;
        m_axis_tready <= 1'b0;
        forever begin
            if (n_digest_words % 16 == 0) busy = ($urandom_range(0, 3) == 0);
            gap = draw_gap(busy);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
            n_digest_words++;
            if (digest_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("ERROR: digest transfer with nothing expected: %h idx %0d",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                exp_d = digest_q.pop_front();
                if (m_axis_tdata !== exp_d.word || m_axis_tuser !== exp_d.idx ||
                    m_axis_tlast !== exp_d.last) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("ERROR: expected %h idx %0d last %0d, got %h idx %0d last %0d",
                                 exp_d.word, exp_d.idx, exp_d.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // End of run.
    initial begin
        wait (sender_done);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (digest_q.size() != 0) n_fail++;
        $display("Hashed %0d messages from %0d input words, checked %0d digest words.",
                 n_messages, n_words_in, n_digest_words);
        if (n_fail == 0)
            $display("sha256_message_hasher_unit_tb: PASS");
        else
            $display("sha256_message_hasher_unit_tb: FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d digest words outstanding.", digest_q.size());
        $display("sha256_message_hasher_unit_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
